>>> design/assert_macros.svh
// Assertion macros for the checker file of this block.
// Include by bare file name; each macro forms one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/icmp_erc_pkg.sv
// Shared constants, types and the checksum fold function of the echo reply checker.
// No dependencies; the parser, the result buffer, the top level and the testbench import it.
`default_nettype none

package icmp_erc_pkg;

  localparam int MAX_PACKET_BYTES = 1024;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int HDR_W            = 6;
  localparam int ICMP_HDR_BYTES   = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_EXPECTED_ID  = 2'd0;
  localparam logic [1:0] REG_EXPECTED_SEQ = 2'd1;

  // Byte offsets within the ICMP header
  localparam logic [2:0] OFF_TYPE   = 3'd0;
  localparam logic [2:0] OFF_CKS_HI = 3'd2;
  localparam logic [2:0] OFF_CKS_LO = 3'd3;
  localparam logic [2:0] OFF_ID_HI  = 3'd4;
  localparam logic [2:0] OFF_ID_LO  = 3'd5;
  localparam logic [2:0] OFF_SEQ_HI = 3'd6;
  localparam logic [2:0] OFF_SEQ_LO = 3'd7;

  localparam logic [7:0] ECHO_REPLY = 8'd0;

  typedef struct packed {
    logic reply_matches;
    logic checksum_ok;
  } icmp_erc_result_t;

  typedef struct packed {
    logic             valid;
    icmp_erc_result_t result;
  } icmp_erc_push_t;

  // Ones'-complement add with end-around carry
  function automatic logic [15:0] csum_add(input logic [15:0] sum, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, sum} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

>>> design/icmp_erc_accum.sv
// Per-byte packet parser: header skip, ICMP field capture and checksum sum.
// Produces one result transaction per packet; depends on icmp_erc_pkg.
`default_nettype none

module icmp_erc_accum import icmp_erc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire logic [15:0]      expected_identifier,
  input  wire logic [15:0]      expected_sequence,
  output icmp_erc_push_t        push
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [HDR_W-1:0] header_bytes, header_bytes_next;
  logic [7:0]       message_type, message_type_next;
  logic [15:0]      captured_identifier, captured_identifier_next;
  logic [15:0]      captured_sequence, captured_sequence_next;
  logic [15:0]      received_checksum, received_checksum_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       pending_high_byte, pending_high_byte_next;

  logic             pos_ok;
  logic [HDR_W-1:0] hdr_eff;
  logic [POS_W-1:0] hdr_ext;
  logic             icmp_hit;
  logic [POS_W-1:0] icmp_off;
  logic             off_in_hdr;
  logic [7:0]       sum_byte;
  logic [POS_W-1:0] icmp_len;
  logic [15:0]      final_sum;
  logic             too_short;

  always_comb begin
    byte_position_next       = byte_position;
    header_bytes_next        = header_bytes;
    message_type_next        = message_type;
    captured_identifier_next = captured_identifier;
    captured_sequence_next   = captured_sequence;
    received_checksum_next   = received_checksum;
    running_sum_next         = running_sum;
    pending_high_byte_next   = pending_high_byte;

    pos_ok     = byte_position < POS_W'(MAX_PACKET_BYTES);
    hdr_eff    = (byte_position == '0) ? {data_byte[3:0], 2'b00} : header_bytes;
    hdr_ext    = {{(POS_W-HDR_W){1'b0}}, hdr_eff};
    icmp_hit   = pos_ok && (byte_position >= hdr_ext);
    icmp_off   = byte_position - hdr_ext;
    off_in_hdr = (icmp_off[POS_W-1:3] == '0);
    sum_byte   = data_byte;

    if (pos_ok) begin
      header_bytes_next  = hdr_eff;
      byte_position_next = byte_position + POS_W'(1);
    end

    if (icmp_hit) begin
      if (off_in_hdr) begin
        case (icmp_off[2:0])
          OFF_TYPE:   message_type_next = data_byte;
          OFF_CKS_HI: received_checksum_next = {data_byte, 8'h00};
          OFF_CKS_LO: received_checksum_next = {received_checksum[15:8], data_byte};
          OFF_ID_HI:  captured_identifier_next = {data_byte, 8'h00};
          OFF_ID_LO:  captured_identifier_next = {captured_identifier[15:8], data_byte};
          OFF_SEQ_HI: captured_sequence_next = {data_byte, 8'h00};
          OFF_SEQ_LO: captured_sequence_next = {captured_sequence[15:8], data_byte};
          default:    ;
        endcase
        // checksum field counts as zero in the sum
        if (icmp_off[2:0] == OFF_CKS_HI || icmp_off[2:0] == OFF_CKS_LO) begin
          sum_byte = 8'h00;
        end
      end
      if (!icmp_off[0]) begin
        pending_high_byte_next = sum_byte;
      end else begin
        running_sum_next       = csum_add(running_sum, {pending_high_byte, sum_byte});
        pending_high_byte_next = 8'h00;
      end
    end

    // end of packet: pad an odd trailing byte, then judge
    icmp_len = (byte_position_next > {{(POS_W-HDR_W){1'b0}}, header_bytes_next}) ?
               byte_position_next - {{(POS_W-HDR_W){1'b0}}, header_bytes_next} : '0;
    final_sum = icmp_len[0] ? csum_add(running_sum_next, {pending_high_byte_next, 8'h00})
                            : running_sum_next;
    too_short = icmp_len < POS_W'(ICMP_HDR_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_accept && last_byte)) begin
      byte_position       <= '0;
      header_bytes        <= '0;
      message_type        <= '0;
      captured_identifier <= '0;
      captured_sequence   <= '0;
      received_checksum   <= '0;
      running_sum         <= '0;
      pending_high_byte   <= '0;
    end else if (byte_accept) begin
      byte_position       <= byte_position_next;
      header_bytes        <= header_bytes_next;
      message_type        <= message_type_next;
      captured_identifier <= captured_identifier_next;
      captured_sequence   <= captured_sequence_next;
      received_checksum   <= received_checksum_next;
      running_sum         <= running_sum_next;
      pending_high_byte   <= pending_high_byte_next;
    end
  end

  always_comb begin
    push.valid                = byte_accept && last_byte;
    push.result.reply_matches = !too_short && (message_type_next == ECHO_REPLY) &&
                                (captured_identifier_next == expected_identifier) &&
                                (captured_sequence_next == expected_sequence);
    push.result.checksum_ok   = !too_short && ((~final_sum) == received_checksum_next);
  end

endmodule

`default_nettype wire

>>> design/icmp_erc_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
// Parts the byte input from the result stall; depends on icmp_erc_pkg.
`default_nettype none

module icmp_erc_out_buf import icmp_erc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  icmp_erc_push_t  push,
  input  wire logic       result_stall,
  output logic            result_valid,
  output logic            reply_matches,
  output logic            checksum_ok,
  output logic            full
);

  icmp_erc_result_t head, skid;
  logic             head_valid, skid_valid;
  logic             pop;

  assign pop = head_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= push.valid;
      end else begin
        head_valid <= push.valid;
      end
    end else if (push.valid) begin
      // head is held: park the new transaction in the skid entry
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      if (skid_valid) begin
        head <= skid;
        skid <= push.result;
      end else begin
        head <= push.result;
      end
    end else if (push.valid) begin
      skid <= push.result;
    end
  end

  assign result_valid  = head_valid;
  assign reply_matches = head.reply_matches;
  assign checksum_ok   = head.checksum_ok;
  assign full          = skid_valid;

endmodule

`default_nettype wire

>>> design/icmp_echo_reply_checker.sv
// A result transaction is registered in the result buffer when the last byte is accepted.
// Throughput: one byte per cycle; the byte input stalls only while two results wait.
// Per-byte work is one ones'-complement add between the packet state and its update.
// Synchronous reset clears the packet state, both expected-value registers and the
// result buffer; packet state also clears after each last byte.
// Top level of the echo reply checker; depends on icmp_erc_pkg, icmp_erc_accum, icmp_erc_out_buf.
`default_nettype none

module icmp_echo_reply_checker import icmp_erc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             reply_matches,
  output logic             checksum_ok,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]    expected_identifier;
  logic [15:0]    expected_sequence;
  logic           byte_accept;
  icmp_erc_push_t push;

  assign cfg_ready   = 1'b1;
  assign byte_accept = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_identifier <= '0;
      expected_sequence   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPECTED_ID:  expected_identifier <= cfg_data;
        REG_EXPECTED_SEQ: expected_sequence   <= cfg_data;
        default:          ;
      endcase
    end
  end

  icmp_erc_accum u_accum (
    .clk                 (clk),
    .rst                 (rst),
    .byte_accept         (byte_accept),
    .data_byte           (data_byte),
    .last_byte           (last_byte),
    .expected_identifier (expected_identifier),
    .expected_sequence   (expected_sequence),
    .push                (push)
  );

  icmp_erc_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .reply_matches (reply_matches),
    .checksum_ok   (checksum_ok),
    .full          (byte_stall)
  );

endmodule

`default_nettype wire

>>> design/icmp_erc_checker.sv
// Port-level checker for the echo reply checker, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module icmp_erc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        byte_valid,
  input wire logic        byte_stall,
  input wire logic        last_byte,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic        reply_matches,
  input wire logic        checksum_ok
);

  logic       last_accept;
  logic       mid_accept;
  logic [1:0] payload;
  assign last_accept = byte_valid && !byte_stall && last_byte;
  assign mid_accept  = byte_valid && !byte_stall && !last_byte;
  assign payload     = {reply_matches, checksum_ok};

  `ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid)
  `ASSERT_NEXT(a_payload_held, clk, rst, result_valid && result_stall, $stable(payload))
  `ASSERT_IMPL(a_result_from_last, clk, rst, $rose(result_valid), $past(last_accept))
  `ASSERT_NEXT(a_mid_byte_silent, clk, rst, mid_accept && !result_valid, !result_valid)
  `ASSERT_IMPL(a_stall_needs_result, clk, rst, byte_stall, result_valid)

endmodule

bind icmp_echo_reply_checker icmp_erc_checker u_icmp_erc_checker (.*);

`default_nettype wire

>>> tb/sv/icmp_echo_reply_checker_tb.sv
// Testbench for the ICMPv4 echo reply checker: a table of directed bytes, then random packets.
// The local predictor tracks the packet state and the expected identifier and sequence.
// Depends on icmp_erc_pkg and icmp_echo_reply_checker.
module icmp_echo_reply_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icmp_erc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  // Slowest run: ~2k bytes (one oversize packet included) with random byte gaps
  // plus random receiver stalls, so this is many times over.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 1100;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 5;

  typedef enum int {
    PK_GOOD, PK_BAD_TYPE, PK_BAD_ID, PK_BAD_SEQ, PK_BAD_CKS, PK_SHORT, PK_NOISE, PK_OVERSIZE
  } pkt_kind_t;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    logic       want_match;
    logic       want_ck;
  } byte_row_t;

  // Short packets first, then an echo reply with header length zero, zero identifier and
  // sequence and an all-ones checksum, then an echo request behind a one-word header with an odd trailing byte.
  localparam byte_row_t DIRECTED_ROWS [0:22] = '{
    {8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
    {8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b1, 1'b1, 1'b1, 1'b1},
    {8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'hAA, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h55, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h08, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h12, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h34, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'hA5, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    {8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        byte_valid   = 1'b0;
  logic [7:0]  data_byte    = 8'h00;
  logic        last_byte    = 1'b0;
  logic        result_stall = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [1:0]  cfg_index    = REG_EXPECTED_ID;
  logic [15:0] cfg_data     = 16'h0000;
  logic        byte_stall;
  logic        result_valid;
  logic        reply_matches;
  logic        checksum_ok;
  logic        cfg_ready;

  int gap_pct       = 0;
  int stall_pct     = 0;
  int error_count   = 0;
  int verdicts_made = 0;
  int cycle_count   = 0;

  icmp_erc_result_t verdict_q[$];

  // Predictor state
  int unsigned pkt_pos  = 0;
  int unsigned hdr_len  = 0;
  logic [7:0]  rx_type  = 8'h00;
  logic [7:0]  pend_hi  = 8'h00;
  logic [15:0] rx_id    = 16'h0000;
  logic [15:0] rx_seq   = 16'h0000;
  logic [15:0] rx_cks   = 16'h0000;
  logic [15:0] ones_sum = 16'h0000;
  logic [15:0] want_id  = 16'h0000;
  logic [15:0] want_seq = 16'h0000;

  icmp_echo_reply_checker dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .reply_matches (reply_matches),
    .checksum_ok   (checksum_ok),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("** icmp_echo_reply_checker: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin : check_verdicts
    icmp_erc_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result transaction, actual match %0b checksum %0b",
                 $time, reply_matches, checksum_ok);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        if (reply_matches !== want.reply_matches) begin
          $display("%0t: reply_matches expected %0b actual %0b",
                   $time, want.reply_matches, reply_matches);
          error_count++;
        end
        if (checksum_ok !== want.checksum_ok) begin
          $display("%0t: checksum_ok expected %0b actual %0b",
                   $time, want.checksum_ok, checksum_ok);
          error_count++;
        end
      end
    end
  end

  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] t;
    t = {1'b0, acc} + {1'b0, word};
    return (t > 17'h0FFFF) ? t[15:0] + 16'd1 : t[15:0];
  endfunction

  // Advance the packet state by one byte; return 1 when a verdict is due.
  function automatic bit absorb_byte(input logic [7:0] b, input logic l,
                                     output icmp_erc_result_t r);
    int unsigned off;
    int unsigned icmp_len;
    logic [7:0]  v;
    r = '0;
    if (pkt_pos < MAX_PACKET_BYTES) begin
      if (pkt_pos == 0) hdr_len = b[3:0] * 4;
      if (pkt_pos >= hdr_len) begin
        off = pkt_pos - hdr_len;
        v = b;
        case (off)
          OFF_TYPE:   rx_type = b;
          OFF_CKS_HI: begin
            rx_cks[15:8] = b;
            v = 8'h00;
          end
          OFF_CKS_LO: begin
            rx_cks[7:0] = b;
            v = 8'h00;
          end
          OFF_ID_HI:  rx_id[15:8] = b;
          OFF_ID_LO:  rx_id[7:0] = b;
          OFF_SEQ_HI: rx_seq[15:8] = b;
          OFF_SEQ_LO: rx_seq[7:0] = b;
          default: ;
        endcase
        if (off[0] == 1'b0) begin
          pend_hi = v;
        end else begin
          ones_sum = ones_add(ones_sum, {pend_hi, v});
          pend_hi = 8'h00;
        end
      end
      pkt_pos++;
    end
    if (!l) return 1'b0;
    icmp_len = (pkt_pos > hdr_len) ? pkt_pos - hdr_len : 0;
    // pad an odd trailing byte with a zero low byte
    if (icmp_len[0]) ones_sum = ones_add(ones_sum, {pend_hi, 8'h00});
    if (icmp_len >= ICMP_HDR_BYTES) begin
      r.reply_matches = (rx_type == ECHO_REPLY) && (rx_id == want_id) && (rx_seq == want_seq);
      r.checksum_ok   = (~ones_sum == rx_cks);
    end
    pkt_pos  = 0;
    hdr_len  = 0;
    rx_type  = 8'h00;
    rx_id    = 16'h0000;
    rx_seq   = 16'h0000;
    rx_cks   = 16'h0000;
    ones_sum = 16'h0000;
    pend_hi  = 8'h00;
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic put_byte(input logic [7:0] b, input logic l, input bit typed,
                          input icmp_erc_result_t typed_res);
    icmp_erc_result_t r;
    while ($urandom_range(99) < gap_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= l;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
    if (absorb_byte(b, l, r)) begin
      verdict_q.push_back(typed ? typed_res : r);
      verdicts_made++;
    end
  endtask

  task automatic wait_until_quiet();
    byte_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    if (idx == REG_EXPECTED_ID) want_id = val;
    else if (idx == REG_EXPECTED_SEQ) want_seq = val;
  endtask

  task automatic set_expected(input logic [15:0] id, input logic [15:0] seq);
    write_reg(REG_EXPECTED_ID, id);
    write_reg(REG_EXPECTED_SEQ, seq);
    cfg_valid <= 1'b0;
  endtask

  function automatic pkt_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 55) return PK_GOOD;
    if (r < 62) return PK_BAD_TYPE;
    if (r < 69) return PK_BAD_ID;
    if (r < 76) return PK_BAD_SEQ;
    if (r < 84) return PK_BAD_CKS;
    if (r < 92) return PK_SHORT;
    return PK_NOISE;
  endfunction

  task automatic send_frame(input pkt_kind_t kind, output int sent);
    logic [7:0]  frame[$];
    logic [7:0]  b0;
    logic [7:0]  ptype;
    logic [15:0] id;
    logic [15:0] seq;
    logic [15:0] sum;
    logic [15:0] cks;
    int          hdr_words;
    int          hdr;
    int          total;
    int          icmp_n;
    int          span;
    hdr_words = ($urandom_range(99) < 60) ? 5 : $urandom_range(15);
    hdr = hdr_words * 4;
    if (kind == PK_NOISE || kind == PK_SHORT) begin
      // noise keeps a random header nibble; short packets end before 8 ICMP bytes
      total = (kind == PK_NOISE) ? $urandom_range(1, 48) : $urandom_range(1, hdr + 7);
      b0 = 8'($urandom);
      if (kind == PK_SHORT) b0[3:0] = 4'(hdr_words);
      frame.push_back(b0);
      for (int i = 1; i < total; i++) frame.push_back(8'($urandom));
    end else begin
      if (kind == PK_OVERSIZE) icmp_n = MAX_PACKET_BYTES - hdr + $urandom_range(1, 40);
      else icmp_n = 8 + (($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(16));
      if (hdr > 0) begin
        b0 = 8'($urandom);
        b0[3:0] = 4'(hdr_words);
        frame.push_back(b0);
        for (int i = 1; i < hdr; i++) frame.push_back(8'($urandom));
      end
      ptype = ECHO_REPLY;
      // with no header the type byte is also byte 0, so its low nibble stays zero
      if (kind == PK_BAD_TYPE)
        ptype = (hdr == 0) ? {4'($urandom_range(1, 15)), 4'h0} : 8'($urandom_range(1, 255));
      id  = want_id;
      seq = want_seq;
      if (kind == PK_BAD_ID) id = id ^ 16'($urandom_range(1, 65535));
      if (kind == PK_BAD_SEQ) seq = seq ^ 16'($urandom_range(1, 65535));
      frame.push_back(ptype);
      frame.push_back(8'($urandom));
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      frame.push_back(id[15:8]);
      frame.push_back(id[7:0]);
      frame.push_back(seq[15:8]);
      frame.push_back(seq[7:0]);
      for (int i = 8; i < icmp_n; i++) frame.push_back(8'($urandom));
      // checksum covers only what survives truncation
      span = ((frame.size() < MAX_PACKET_BYTES) ? frame.size() : MAX_PACKET_BYTES) - hdr;
      sum = 16'h0000;
      for (int i = 0; i < span; i += 2)
        sum = ones_add(sum, {frame[hdr + i], (i + 1 < span) ? frame[hdr + i + 1] : 8'h00});
      cks = ~sum;
      if (kind == PK_BAD_CKS) cks = cks ^ 16'($urandom_range(1, 65535));
      frame[hdr + 2] = cks[15:8];
      frame[hdr + 3] = cks[7:0];
    end
    for (int i = 0; i < frame.size(); i++)
      put_byte(frame[i], i == frame.size() - 1, 1'b0, '0);
    sent = frame.size();
  endtask

  initial begin : stimulus
    int gap_of   [NUM_PHASES];
    int stall_of [NUM_PHASES];
    int phase_bytes;
    int n;
    int pkts;
    gap_of   = '{0, 79, 0, 23, 0};
    stall_of = '{0, 0, 79, 23, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 23; i++)
      put_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].l, DIRECTED_ROWS[i].typed,
               {DIRECTED_ROWS[i].want_match, DIRECTED_ROWS[i].want_ck});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_until_quiet();
      case (ph)
        0: set_expected(16'hFFFF, 16'hFFFF);
        1: set_expected(16'h0000, 16'h0000);
        2: set_expected(16'($urandom), 16'($urandom));
        3: set_expected(16'h0000, 16'hFFFF);
        default: set_expected(16'hFFFF, 16'h0000);
      endcase
      gap_pct   = gap_of[ph];
      stall_pct = stall_of[ph];
      phase_bytes = 0;
      pkts = 0;
      // the oversize packet uses up the byte budget of its phase
      if (ph == 0) begin
        send_frame(PK_OVERSIZE, n);
        phase_bytes = n;
      end
      while (phase_bytes < RANDOM_BYTES / NUM_PHASES) begin
        // hold the sender until every verdict is back now and then
        if (pkts % 9 == 8) wait_until_quiet();
        send_frame(pick_kind(), n);
        phase_bytes += n;
        pkts++;
      end
    end

    stall_pct = 0;
    wait_until_quiet();
    if (error_count == 0) begin
      $display("** icmp_echo_reply_checker: PASSED **");
    end else begin
      $display("** icmp_echo_reply_checker: FAILED **");
    end
    $finish;
  end

endmodule
